>>> hdl/mt_pkg.sv
package mt_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS);
	localparam int WORD_W       = 32;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam word_t TWIST_MATRIX  = 32'h9908_b0df;
	localparam word_t HIGH_BIT_MASK = 32'h8000_0000;
	localparam word_t LOW_BITS_MASK = 32'h7fff_ffff;
	localparam word_t SEED_MULT     = 32'd1812433253;
	localparam word_t TEMPER_B      = 32'h9d2c_5680;
	localparam word_t TEMPER_C      = 32'hefc6_0000;
	localparam word_t RESET_SEED    = 32'd5489;

	localparam idx_t LAST_IDX  = IDX_W'(STATE_WORDS - 1);
	localparam idx_t FAR_SPLIT = IDX_W'(STATE_WORDS - TWIST_OFFSET);
	localparam idx_t FAR_ADD   = IDX_W'(TWIST_OFFSET);

	localparam logic MODE_DRAW   = 1'b0;
	localparam logic MODE_RESEED = 1'b1;

	function automatic idx_t next_idx(input idx_t p);
		return (p == LAST_IDX) ? '0 : idx_t'(p + idx_t'(1));
	endfunction

	function automatic idx_t far_idx(input idx_t p);
		return (p < FAR_SPLIT) ? idx_t'(p + FAR_ADD) : idx_t'(p - FAR_SPLIT);
	endfunction

	function automatic word_t twist_word(input word_t upper_src, input word_t lower_src,
			input word_t far_src);
		word_t y;
		word_t r;
		y = (upper_src & HIGH_BIT_MASK) | (lower_src & LOW_BITS_MASK);
		r = far_src ^ (y >> 1);
		if (y[0]) begin
			r = r ^ TWIST_MATRIX;
		end
		return r;
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

>>> hdl/mt_ram.sv
module mt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hdl/mersenne_twister_generator.sv
// MT19937 generator. A draw item (mode 0) returns one tempered 32-bit word: the
// state word is twisted on the fly as it is drawn, and the two read ports of the
// state RAM fetch the words the next draw needs while the current one is written
// back, so draws run at one item per cycle as long as each result is taken when
// shown. A reseed item (mode 1) gives no result and runs the seeding sequencer,
// one multiply per state word, with in_ready low until all 624 words are written.
// The same pass with seed 5489 runs right after reset before the first item is
// taken.
module mersenne_twister_generator
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);

	typedef enum logic {ST_FILL, ST_IDLE} state_t;

	state_t state_q;
	idx_t   fill_idx_q;
	word_t  prev_q;
	idx_t   pos_q;
	word_t  cur_q;
	logic   out_valid_q;
	word_t  out_word_q;

	logic  draw_go;
	logic  reseed_go;
	idx_t  pos_next;
	word_t rd_next;
	word_t rd_far;
	word_t twisted;
	word_t fill_word;
	logic  ram_we;
	idx_t  ram_waddr;
	word_t ram_wdata;

	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign draw_go     = in_valid && in_ready && (mode == MODE_DRAW);
	assign reseed_go   = in_valid && in_ready && (mode == MODE_RESEED);
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	assign twisted = twist_word(cur_q, rd_next, rd_far);

	// word zero is the seed itself, the rest follow the seeding recurrence
	always_comb begin
		if (fill_idx_q == '0) begin
			fill_word = prev_q;
		end else begin
			fill_word = word_t'(SEED_MULT * (prev_q ^ (prev_q >> 30)))
				+ word_t'(fill_idx_q);
		end
	end

	always_comb begin
		if (draw_go) begin
			pos_next = next_idx(pos_q);
		end else if (reseed_go) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q;
		end
	end

	assign ram_we    = (state_q == ST_FILL) || draw_go;
	assign ram_waddr = (state_q == ST_FILL) ? fill_idx_q : pos_q;
	assign ram_wdata = (state_q == ST_FILL) ? fill_word : twisted;

	// reads run ahead at the position of the next draw
	mt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(next_idx(pos_next)),
		.raddr_b(far_idx(pos_next)),
		.rdata_a(rd_next),
		.rdata_b(rd_far)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_idx_q  <= '0;
			prev_q      <= RESET_SEED;
			pos_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			pos_q <= pos_next;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					prev_q <= fill_word;
					if (fill_idx_q == '0) begin
						cur_q <= fill_word;
					end
					if (fill_idx_q == LAST_IDX) begin
						fill_idx_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						fill_idx_q <= idx_t'(fill_idx_q + idx_t'(1));
					end
				end
				ST_IDLE: begin
					if (draw_go) begin
						cur_q       <= rd_next;
						out_word_q  <= temper(twisted);
						out_valid_q <= 1'b1;
					end else if (reseed_go) begin
						prev_q     <= seed_value;
						fill_idx_q <= '0;
						state_q    <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

endmodule

>>> hdl/mt_checker.sv
module mt_checker
	import mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic [31:0] seed_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] random_word
);

	// a waiting result holds its word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_word))
		else $error("result changed while stalled");

	// every accepted draw shows a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_DRAW |=> out_valid)
		else $error("draw item gave no result");

	// a reseed gives no result and the input is closed as seeding begins
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_RESEED |=> !out_valid && !in_ready)
		else $error("reseed item misbehaved");

	// an item is taken only when the output register is free or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("item taken over a waiting result");

	// a reseed item carries a fully known seed
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_RESEED |-> !$isunknown(seed_value))
		else $error("seed value unknown");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (.*);
